@@ src/tshap_pkg.sv @@
// Shared types, field codes and helpers for the transport stream header parser.
// No dependencies; imported by tshap_front, tshap_back and the top level.
package tshap_pkg;

  localparam int unsigned PACKET_BYTES_MIN     = 188;
  localparam int unsigned PACKET_BYTES_RESET   = 188;
  localparam int unsigned MAX_PACKET_BYTES_DEF = 208;
  localparam int unsigned QUEUE_DEPTH_DEF      = 4;
  localparam int unsigned TAIL_SLOTS           = 3;

  // field codes
  localparam logic [5:0] FC_SYNC          = 6'd0;
  localparam logic [5:0] FC_TEI           = 6'd1;
  localparam logic [5:0] FC_PID           = 6'd4;
  localparam logic [5:0] FC_SCRAMBLING    = 6'd5;
  localparam logic [5:0] FC_AF_CONTROL    = 6'd6;
  localparam logic [5:0] FC_CONTINUITY    = 6'd7;
  localparam logic [5:0] FC_AF            = 6'd8;
  localparam logic [5:0] FC_AF_LEN        = 6'd9;
  localparam logic [5:0] FC_DISCONTINUITY = 6'd10;
  localparam logic [5:0] FC_PCR_BASE      = 6'd18;
  localparam logic [5:0] FC_OPCR_BASE     = 6'd21;
  localparam logic [5:0] FC_SPLICE_CD     = 6'd24;
  localparam logic [5:0] FC_TPD_LEN       = 6'd25;
  localparam logic [5:0] FC_PRIVATE       = 6'd26;
  localparam logic [5:0] FC_EXT_LEN       = 6'd27;
  localparam logic [5:0] FC_LTW_FLAG      = 6'd28;
  localparam logic [5:0] FC_LTW_VALID     = 6'd32;
  localparam logic [5:0] FC_PWR_RESERVED  = 6'd34;
  localparam logic [5:0] FC_SPLICE_TYPE   = 6'd36;
  localparam logic [5:0] FC_EXT_RESERVED  = 6'd43;
  localparam logic [5:0] FC_STUFFING      = 6'd44;
  localparam logic [5:0] FC_DATA          = 6'd45;
  localparam logic [5:0] FC_INVALID       = 6'd46;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  field_code;
    logic [32:0] field_value;
    logic [10:0] bit_offset;
    logic [10:0] bit_length;
    logic        is_region;
    logic        last_of_item;
  } rec_item_t;

  // what fixed records a byte produces
  typedef enum logic [3:0] {
    MK_NONE, MK_SYNC, MK_H1, MK_H2, MK_H3, MK_AFLEN, MK_AFFLAGS, MK_PCR, MK_OPCR,
    MK_SPLICE, MK_TPDLEN, MK_EXTLEN, MK_EXTFLAGS, MK_LTW, MK_PWR, MK_SEAM
  } main_kind_t;

  typedef struct packed {
    logic [5:0]  code;
    logic [10:0] off;
    logic [10:0] len;
  } region_t;

  // one queued transaction: fixed records plus up to three trailing regions
  typedef struct packed {
    main_kind_t           kind;
    logic [7:0]           byte_val;
    logic [7:0]           pos;
    logic [47:0]          acc;
    logic [1:0]           tail_count;
    region_t [TAIL_SLOTS-1:0] tail;
  } ev_t;

  function automatic logic [3:0] main_count(input main_kind_t kind);
    case (kind)
      MK_SYNC, MK_H2, MK_SPLICE, MK_TPDLEN, MK_EXTLEN: main_count = 4'd1;
      MK_AFLEN, MK_LTW, MK_PWR:                         main_count = 4'd2;
      MK_H1, MK_H3, MK_PCR, MK_OPCR:                    main_count = 4'd3;
      MK_EXTFLAGS:                                      main_count = 4'd4;
      MK_SEAM:                                          main_count = 4'd7;
      MK_AFFLAGS:                                       main_count = 4'd8;
      default:                                          main_count = 4'd0;
    endcase
  endfunction

endpackage

@@ src/tshap_queue.sv @@
// Small flop-based FIFO between the parser front end and the record emitter.
// Depends on nothing but its parameters.
module tshap_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output logic [WIDTH-1:0] head
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ src/tshap_front.sv @@
// Parser front end: takes one byte per transaction, tracks the packet syntax
// and queues a compact record description. Uses tshap_pkg.
module tshap_front #(
  parameter int unsigned MAX_PACKET_BYTES = tshap_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         packet_bytes,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  tshap_pkg::in_item_t byte_item,
  input  logic               q_full,
  output logic               ev_push,
  output tshap_pkg::ev_t     ev
);
  import tshap_pkg::*;

  typedef enum logic [4:0] {
    PH_SYNC, PH_H1, PH_H2, PH_H3, PH_AFLEN, PH_AFFLAGS, PH_PCR, PH_OPCR, PH_SPLICE,
    PH_TPDLEN, PH_PRIV, PH_EXTLEN, PH_EXTFLAGS, PH_LTW, PH_PWR, PH_SEAM, PH_IDLE
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  position, position_next;
  logic [7:0]  af_remaining, af_remaining_next;
  logic [7:0]  ext_remaining, ext_remaining_next;
  logic [7:0]  private_remaining, private_remaining_next;
  logic [7:0]  pending_flags, pending_flags_next;
  logic [1:0]  control_bits, control_bits_next;
  logic [47:0] accumulator, accumulator_next;
  logic [7:0]  len;
  logic        accept;

  // packet length clamped to the supported range
  always_comb begin
    if (packet_bytes < 8'(PACKET_BYTES_MIN)) begin
      len = 8'(PACKET_BYTES_MIN);
    end else if (packet_bytes > 8'(MAX_PACKET_BYTES)) begin
      len = 8'(MAX_PACKET_BYTES);
    end else begin
      len = packet_bytes;
    end
  end

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  always_comb begin
    phase_t            ph;
    logic [7:0]        af, ext, priv, pend, b, p;
    logic [1:0]        ctrl;
    logic [47:0]       acc;
    logic [47:0]       acc_ev;
    logic [9:0]        nxt;
    logic [8:0]        b1;
    logic              f_ext_next, f_ext_fin, f_ext_inv;
    logic              f_af_next, f_af_fin, f_af_inv, f_pay;
    main_kind_t        kind;
    region_t [TAIL_SLOTS-1:0] tl;
    logic [1:0]        tc;

    b = byte_item.stream_byte;
    if (byte_item.packet_start || position >= len) begin
      ph = PH_SYNC; p = '0; af = '0; ext = '0; priv = '0; pend = '0;
      ctrl = '0; acc = '0;
    end else begin
      ph = phase; p = position; af = af_remaining; ext = ext_remaining;
      priv = private_remaining; pend = pending_flags; ctrl = control_bits;
      acc = accumulator;
    end
    f_ext_next = 1'b0; f_ext_fin = 1'b0; f_ext_inv = 1'b0;
    f_af_next = 1'b0; f_af_fin = 1'b0; f_af_inv = 1'b0; f_pay = 1'b0;
    kind = MK_NONE;
    tl   = '0;
    tc   = '0;
    nxt  = '0;
    b1   = {1'b0, b} + 9'd1;

    case (ph)
      PH_SYNC: begin
        kind = MK_SYNC;
        ph   = PH_H1;
      end
      PH_H1: begin
        kind = MK_H1;
        acc  = {43'd0, b[4:0]};
        ph   = PH_H2;
      end
      PH_H2: begin
        kind = MK_H2;
        ph   = PH_H3;
      end
      PH_H3: begin
        kind = MK_H3;
        ctrl = b[5:4];
        if (ctrl[1]) begin
          ph = PH_AFLEN;
        end else begin
          f_pay = 1'b1;
          nxt   = 10'd4;
        end
      end
      PH_AFLEN: begin
        if (b1 > ({1'b0, len} - 9'd4)) begin
          tl[tc] = '{code: FC_INVALID, off: 11'd32, len: 11'({len - 8'd4, 3'b000})};
          tc     = tc + 2'd1;
          ph     = PH_IDLE;
        end else begin
          kind = MK_AFLEN;
          if (b == 8'd0) begin
            f_pay = 1'b1;
            nxt   = 10'd5;
          end else begin
            af = b;
            ph = PH_AFFLAGS;
          end
        end
      end
      PH_AFFLAGS: begin
        kind = MK_AFFLAGS;
        if (af != 8'd0) af = af - 8'd1;
        pend      = {3'b000, b[4:0]};
        f_af_next = 1'b1;
        nxt       = {2'b00, p} + 10'd1;
      end
      PH_PCR, PH_OPCR: begin
        acc = {acc[39:0], b};
        if (af != 8'd0) af = af - 8'd1;
        if (priv != 8'd0) priv = priv - 8'd1;
        if (priv == 8'd0) begin
          kind      = (ph == PH_PCR) ? MK_PCR : MK_OPCR;
          f_af_next = 1'b1;
          nxt       = {2'b00, p} + 10'd1;
        end
      end
      PH_SPLICE: begin
        kind = MK_SPLICE;
        if (af != 8'd0) af = af - 8'd1;
        f_af_next = 1'b1;
        nxt       = {2'b00, p} + 10'd1;
      end
      PH_TPDLEN: begin
        kind = MK_TPDLEN;
        if (af != 8'd0) af = af - 8'd1;
        nxt = {2'b00, p} + 10'd1;
        if (b > af) begin
          f_af_inv = 1'b1;
        end else begin
          tl[tc] = '{code: FC_PRIVATE, off: 11'({nxt, 3'b000}), len: 11'({b, 3'b000})};
          tc     = tc + 2'd1;
          af     = af - b;
          if (b == 8'd0) begin
            f_af_next = 1'b1;
          end else begin
            priv = b;
            ph   = PH_PRIV;
          end
        end
      end
      PH_PRIV: begin
        if (priv != 8'd0) priv = priv - 8'd1;
        if (priv == 8'd0) begin
          f_af_next = 1'b1;
          nxt       = {2'b00, p} + 10'd1;
        end
      end
      PH_EXTLEN: begin
        if (b1 > {1'b0, af}) begin
          f_af_inv = 1'b1;
          nxt      = {2'b00, p};
        end else begin
          kind = MK_EXTLEN;
          af   = af - b1[7:0];
          ext  = b;
          if (b == 8'd0) begin
            f_ext_fin = 1'b1;
            nxt       = {2'b00, p} + 10'd1;
          end else begin
            ph = PH_EXTFLAGS;
          end
        end
      end
      PH_EXTFLAGS: begin
        kind = MK_EXTFLAGS;
        if (ext != 8'd0) ext = ext - 8'd1;
        pend       = {b[7:5], 5'b00000};
        f_ext_next = 1'b1;
        nxt        = {2'b00, p} + 10'd1;
      end
      PH_LTW, PH_PWR, PH_SEAM: begin
        acc = {acc[39:0], b};
        if (ext != 8'd0) ext = ext - 8'd1;
        if (priv != 8'd0) priv = priv - 8'd1;
        if (priv == 8'd0) begin
          kind       = (ph == PH_LTW) ? MK_LTW : (ph == PH_PWR) ? MK_PWR : MK_SEAM;
          f_ext_next = 1'b1;
          nxt        = {2'b00, p} + 10'd1;
        end
      end
      default: begin
        ph = PH_IDLE;
      end
    endcase

    // finished field value, before a following field clears the accumulator
    acc_ev = acc;

    // extension flag walk
    if (f_ext_next) begin
      if (pend[7]) begin
        pend[7] = 1'b0;
        if (ext < 8'd2) f_ext_inv = 1'b1;
        else begin ph = PH_LTW; priv = 8'd2; acc = '0; end
      end else if (pend[6]) begin
        pend[6] = 1'b0;
        if (ext < 8'd3) f_ext_inv = 1'b1;
        else begin ph = PH_PWR; priv = 8'd3; acc = '0; end
      end else if (pend[5]) begin
        pend[5] = 1'b0;
        if (ext < 8'd5) f_ext_inv = 1'b1;
        else begin ph = PH_SEAM; priv = 8'd5; acc = '0; end
      end else begin
        f_ext_fin = 1'b1;
      end
    end
    if (f_ext_inv) begin
      tl[tc]   = '{code: FC_INVALID, off: 11'({nxt, 3'b000}), len: 11'({ext, 3'b000})};
      tc       = tc + 2'd1;
      nxt      = nxt + {2'b00, ext};
      f_af_fin = 1'b1;
    end
    if (f_ext_fin) begin
      if (ext != 8'd0) begin
        tl[tc] = '{code: FC_EXT_RESERVED, off: 11'({nxt, 3'b000}),
                   len: 11'({ext, 3'b000})};
        tc     = tc + 2'd1;
      end
      nxt      = nxt + {2'b00, ext};
      f_af_fin = 1'b1;
    end

    // adaptation field flag walk
    if (f_af_next) begin
      if (pend[4]) begin
        pend[4] = 1'b0;
        if (af < 8'd6) f_af_inv = 1'b1;
        else begin ph = PH_PCR; priv = 8'd6; acc = '0; end
      end else if (pend[3]) begin
        pend[3] = 1'b0;
        if (af < 8'd6) f_af_inv = 1'b1;
        else begin ph = PH_OPCR; priv = 8'd6; acc = '0; end
      end else if (pend[2]) begin
        pend[2] = 1'b0;
        if (af == 8'd0) f_af_inv = 1'b1;
        else ph = PH_SPLICE;
      end else if (pend[1]) begin
        pend[1] = 1'b0;
        if (af == 8'd0) f_af_inv = 1'b1;
        else ph = PH_TPDLEN;
      end else if (pend[0]) begin
        pend[0] = 1'b0;
        if (af == 8'd0) f_af_inv = 1'b1;
        else ph = PH_EXTLEN;
      end else begin
        f_af_fin = 1'b1;
      end
    end
    if (f_af_inv) begin
      tl[tc] = '{code: FC_INVALID, off: 11'({nxt, 3'b000}), len: 11'({af, 3'b000})};
      tc     = tc + 2'd1;
      nxt    = nxt + {2'b00, af};
      f_pay  = 1'b1;
    end
    if (f_af_fin) begin
      if (af != 8'd0) begin
        tl[tc] = '{code: FC_STUFFING, off: 11'({nxt, 3'b000}), len: 11'({af, 3'b000})};
        tc     = tc + 2'd1;
      end
      nxt   = nxt + {2'b00, af};
      f_pay = 1'b1;
    end

    // payload region runs to the end of the packet
    if (f_pay) begin
      if (ctrl[0]) begin
        tl[tc] = '{code: FC_DATA, off: 11'({nxt, 3'b000}),
                   len: (nxt < {2'b00, len}) ? 11'({{2'b00, len} - nxt, 3'b000}) : 11'd0};
        tc     = tc + 2'd1;
      end
      ph = PH_IDLE;
    end

    phase_next             = ph;
    position_next          = p + 8'd1;
    af_remaining_next      = af;
    ext_remaining_next     = ext;
    private_remaining_next = priv;
    pending_flags_next     = pend;
    control_bits_next      = ctrl;
    accumulator_next       = acc;

    ev.kind       = kind;
    ev.byte_val   = b;
    ev.pos        = p;
    ev.acc        = acc_ev;
    ev.tail_count = tc;
    ev.tail       = tl;
    ev_push       = accept && ((kind != MK_NONE) || (tc != 2'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SYNC;
      position          <= '0;
      af_remaining      <= '0;
      ext_remaining     <= '0;
      private_remaining <= '0;
      pending_flags     <= '0;
      control_bits      <= '0;
      accumulator       <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      position          <= position_next;
      af_remaining      <= af_remaining_next;
      ext_remaining     <= ext_remaining_next;
      private_remaining <= private_remaining_next;
      pending_flags     <= pending_flags_next;
      control_bits      <= control_bits_next;
      accumulator       <= accumulator_next;
    end
  end

endmodule

@@ src/tshap_back.sv @@
// Record emitter: expands the queued transaction at the head into field records,
// one per cycle unless stalled, into a registered output stage. Uses tshap_pkg.
module tshap_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                ev_valid,
  input  tshap_pkg::ev_t      ev,
  output logic                ev_pop,
  output logic                rec_valid,
  input  logic                rec_stall,
  output tshap_pkg::rec_item_t rec_item
);
  import tshap_pkg::*;

  function automatic rec_item_t main_rec(input main_kind_t kind, input logic [3:0] idx,
                                         input logic [7:0] b, input logic [7:0] p,
                                         input logic [47:0] acc);
    rec_item_t   r;
    logic [10:0] pb, s;
    logic [5:0]  ix;
    pb = {p, 3'b000};
    ix = {2'b00, idx};
    r  = '0;
    case (kind)
      MK_SYNC: begin
        r.field_code = FC_SYNC; r.field_value = {25'd0, b};
        r.bit_offset = 11'd0; r.bit_length = 11'd8;
      end
      MK_H1: begin
        r.field_code = FC_TEI + ix; r.field_value = {32'd0, b[3'd7 - idx[2:0]]};
        r.bit_offset = 11'd8 + {7'd0, idx}; r.bit_length = 11'd1;
      end
      MK_H2: begin
        r.field_code = FC_PID; r.field_value = {20'd0, acc[4:0], b};
        r.bit_offset = 11'd11; r.bit_length = 11'd13;
      end
      MK_H3: begin
        case (idx)
          4'd0: begin
            r.field_code = FC_SCRAMBLING; r.field_value = {31'd0, b[7:6]};
            r.bit_offset = 11'd24; r.bit_length = 11'd2;
          end
          4'd1: begin
            r.field_code = FC_AF_CONTROL; r.field_value = {31'd0, b[5:4]};
            r.bit_offset = 11'd26; r.bit_length = 11'd2;
          end
          default: begin
            r.field_code = FC_CONTINUITY; r.field_value = {29'd0, b[3:0]};
            r.bit_offset = 11'd28; r.bit_length = 11'd4;
          end
        endcase
      end
      MK_AFLEN: begin
        r.bit_offset = 11'd32;
        if (idx == 4'd0) begin
          r.field_code = FC_AF; r.is_region = 1'b1;
          r.bit_length = 11'({{1'b0, b} + 9'd1, 3'b000});
        end else begin
          r.field_code = FC_AF_LEN; r.field_value = {25'd0, b};
          r.bit_length = 11'd8;
        end
      end
      MK_AFFLAGS: begin
        r.field_code = FC_DISCONTINUITY + ix; r.field_value = {32'd0, b[3'd7 - idx[2:0]]};
        r.bit_offset = pb + {7'd0, idx}; r.bit_length = 11'd1;
      end
      MK_PCR, MK_OPCR: begin
        s = pb - 11'd40;
        r.field_code = ((kind == MK_PCR) ? FC_PCR_BASE : FC_OPCR_BASE) + ix;
        case (idx)
          4'd0: begin
            r.field_value = acc[47:15]; r.bit_offset = s; r.bit_length = 11'd33;
          end
          4'd1: begin
            r.field_value = {27'd0, acc[14:9]}; r.bit_offset = s + 11'd33;
            r.bit_length = 11'd6;
          end
          default: begin
            r.field_value = {24'd0, acc[8:0]}; r.bit_offset = s + 11'd39;
            r.bit_length = 11'd9;
          end
        endcase
      end
      MK_SPLICE, MK_TPDLEN, MK_EXTLEN: begin
        r.field_code  = (kind == MK_SPLICE) ? FC_SPLICE_CD :
                        (kind == MK_TPDLEN) ? FC_TPD_LEN : FC_EXT_LEN;
        r.field_value = {25'd0, b}; r.bit_offset = pb; r.bit_length = 11'd8;
      end
      MK_EXTFLAGS: begin
        r.field_code = FC_LTW_FLAG + ix; r.bit_offset = pb + {7'd0, idx};
        if (idx == 4'd3) begin
          r.field_value = {28'd0, b[4:0]}; r.bit_length = 11'd5;
        end else begin
          r.field_value = {32'd0, b[3'd7 - idx[2:0]]}; r.bit_length = 11'd1;
        end
      end
      MK_LTW: begin
        s = pb - 11'd8;
        r.field_code = FC_LTW_VALID + ix;
        if (idx == 4'd0) begin
          r.field_value = {32'd0, acc[15]}; r.bit_offset = s; r.bit_length = 11'd1;
        end else begin
          r.field_value = {18'd0, acc[14:0]}; r.bit_offset = s + 11'd1;
          r.bit_length = 11'd15;
        end
      end
      MK_PWR: begin
        s = pb - 11'd16;
        r.field_code = FC_PWR_RESERVED + ix;
        if (idx == 4'd0) begin
          r.field_value = {31'd0, acc[23:22]}; r.bit_offset = s; r.bit_length = 11'd2;
        end else begin
          r.field_value = {11'd0, acc[21:0]}; r.bit_offset = s + 11'd2;
          r.bit_length = 11'd22;
        end
      end
      MK_SEAM: begin
        s = pb - 11'd32;
        r.field_code = FC_SPLICE_TYPE + ix;
        case (idx)
          4'd0: begin
            r.field_value = {29'd0, acc[39:36]}; r.bit_offset = s; r.bit_length = 11'd4;
          end
          4'd1: begin
            r.field_value = {30'd0, acc[35:33]}; r.bit_offset = s + 11'd4;
            r.bit_length = 11'd3;
          end
          4'd2: begin
            r.field_value = {32'd0, acc[32]}; r.bit_offset = s + 11'd7;
            r.bit_length = 11'd1;
          end
          4'd3: begin
            r.field_value = {18'd0, acc[31:17]}; r.bit_offset = s + 11'd8;
            r.bit_length = 11'd15;
          end
          4'd4: begin
            r.field_value = {32'd0, acc[16]}; r.bit_offset = s + 11'd23;
            r.bit_length = 11'd1;
          end
          4'd5: begin
            r.field_value = {18'd0, acc[15:1]}; r.bit_offset = s + 11'd24;
            r.bit_length = 11'd15;
          end
          default: begin
            r.field_value = {32'd0, acc[0]}; r.bit_offset = s + 11'd39;
            r.bit_length = 11'd1;
          end
        endcase
      end
      default: r = '0;
    endcase
    main_rec = r;
  endfunction

  logic [3:0] idx;
  logic [3:0] mcnt, total, tix;
  logic       emit, last;
  rec_item_t  rec;

  always_comb begin
    mcnt  = main_count(ev.kind);
    total = mcnt + {2'b00, ev.tail_count};
    last  = (idx == total - 4'd1);
    emit  = ev_valid && (!rec_valid || !rec_stall);
    tix   = idx - mcnt;
    if (idx < mcnt) begin
      rec = main_rec(ev.kind, idx, ev.byte_val, ev.pos, ev.acc);
    end else begin
      rec             = '0;
      rec.field_code  = ev.tail[tix[1:0]].code;
      rec.bit_offset  = ev.tail[tix[1:0]].off;
      rec.bit_length  = ev.tail[tix[1:0]].len;
      rec.is_region   = 1'b1;
    end
    rec.last_of_item = last;
    ev_pop           = emit && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      rec_valid <= 1'b0;
    end else if (emit) begin
      idx       <= last ? 4'd0 : idx + 4'd1;
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rec_item <= rec;
    end
  end

endmodule

@@ src/ts_header_adaptation_parser.sv @@
// Top level of the transport stream header / adaptation field parser.
// Instantiates tshap_front, tshap_queue and tshap_back; uses tshap_pkg.
//
// Usage:
//   Byte channel (byte_valid / byte_stall / byte_item): one packet byte per
//   transaction, packet_start high on byte 0. A byte after a full packet
//   without packet_start begins a new packet.
//   Record channel (rec_valid / rec_stall / rec_item): one field record per
//   transaction; last_of_item marks the final record caused by a byte. Bytes
//   that cause no record produce nothing on this channel.
//   Config channel (cfg_valid / cfg_ready / cfg_data): packet length in bytes,
//   clamped to 188..MAX_PACKET_BYTES; write only while the block is idle.
// Throughput: the front end takes one byte per cycle while the queue has room;
//   the back end sends one record per cycle while rec_stall is low, and a byte
//   gives up to 10 records (adaptation flag bytes).
// Record path: a byte's transaction is written into the queue when the byte is
//   accepted; its first record is then loaded into the output register, which
//   raises rec_valid.
// Reset (rst, synchronous): parser returns to the sync byte, queue and output
//   stage empty, packet length back to 188.
// Receiver stall: the output register holds its record; the queue absorbs
//   QUEUE_DEPTH transactions, then byte_stall rises.
module ts_header_adaptation_parser #(
  parameter int unsigned MAX_PACKET_BYTES = tshap_pkg::MAX_PACKET_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH      = tshap_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  tshap_pkg::in_item_t  byte_item,
  output logic                 rec_valid,
  input  logic                 rec_stall,
  output tshap_pkg::rec_item_t rec_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import tshap_pkg::*;

  localparam int unsigned EV_W = $bits(ev_t);

  logic [7:0] packet_bytes;
  logic       q_full, ev_push, head_valid, ev_pop;
  ev_t        ev_in, ev_head;
  logic [EV_W-1:0] head_bits;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_bytes <= 8'(PACKET_BYTES_RESET);
    end else if (cfg_valid) begin
      packet_bytes <= cfg_data;
    end
  end

  tshap_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .packet_bytes (packet_bytes),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .q_full       (q_full),
    .ev_push      (ev_push),
    .ev           (ev_in)
  );

  // decouples byte intake from record output
  tshap_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EV_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (ev_push),
    .wdata      (ev_in),
    .pop        (ev_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head_bits)
  );

  assign ev_head = ev_t'(head_bits);

  tshap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (head_valid),
    .ev        (ev_head),
    .ev_pop    (ev_pop),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_item  (rec_item)
  );

endmodule
